### design/progressive_accum_framebuffer_assert.svh
// Assertion macros used by the framebuffer RTL.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef PROGRESSIVE_ACCUM_FRAMEBUFFER_ASSERT_SVH
`define PROGRESSIVE_ACCUM_FRAMEBUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PAFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAFB_ASSERT(label, clk, rst, prop, msg)
`define PAFB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### design/pafb_pkg.sv
// Shared types, constants and helper functions of the framebuffer.
// No dependencies.
package pafb_pkg;

   localparam int PAFB_MAX_WIDTH        = 256;
   localparam int PAFB_MAX_HEIGHT       = 256;
   localparam int PAFB_MAX_BLOCK_LOG2   = 4;
   localparam int PAFB_GAMMA_INDEX_BITS = 12;

   localparam int SAMPLE_W = 24;
   localparam int CSR_W    = 9;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_SPLAT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_BLACK = 2'd2
   } pafb_kind_type;

   typedef struct packed {
      logic clearing;
   } pafb_status_type;

   function automatic logic [31:0] pafb_sat_add(input logic [31:0] a,
                                                input logic [SAMPLE_W-1:0] b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Smallest index i with i^5 * 255^11 >= b^11 * N^5, N = 2^gbits.
   function automatic int pafb_gamma_thr(input int b, input int gbits);
      logic [191:0] lhs;
      logic [191:0] rhs;
      logic [191:0] p255;
      int n;
      int lo;
      int hi;
      int mid;
      n = 1 << gbits;
      lhs = 192'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 192'(b);
      for (int i = 0; i < 5; i++) lhs = lhs * 192'(n);
      p255 = 192'd1;
      for (int i = 0; i < 11; i++) p255 = p255 * 192'd255;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         rhs = p255;
         for (int i = 0; i < 5; i++) rhs = rhs * 192'(mid);
         if (rhs >= lhs) hi = mid;
         else lo = mid + 1;
      end
      return lo;
   endfunction

endpackage

### design/pafb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pafb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wdata;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/pafb_queue.sv
// Two-entry queue of packed words between the framebuffer stages.
// No dependencies.
module pafb_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

### design/pafb_front.sv
// Front stage: configuration registers, request intake and classification.
// Depends on pafb_pkg.
module pafb_front import pafb_pkg::*; #(
   parameter int MAX_WIDTH      = PAFB_MAX_WIDTH,
   parameter int MAX_HEIGHT     = PAFB_MAX_HEIGHT,
   parameter int MAX_BLOCK_LOG2 = PAFB_MAX_BLOCK_LOG2,
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = $clog2(DEPTH),
   localparam int BLW   = MAX_BLOCK_LOG2 + 1,
   localparam int CMD_W = 2 + AW + 2 * BLW + 3 + 4 * SAMPLE_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   input  logic                push,
   output logic                full,
   input  logic                req_type,
   input  logic [7:0]          req_pos_x,
   input  logic [7:0]          req_pos_y,
   input  logic [2:0]          req_block_log2,
   input  logic [SAMPLE_W-1:0] req_sample_red,
   input  logic [SAMPLE_W-1:0] req_sample_green,
   input  logic [SAMPLE_W-1:0] req_sample_blue,
   input  logic [SAMPLE_W-1:0] req_sample_weight,
   input  pafb_status_type     status,
   input  logic                q_full,
   output logic                q_push,
   output logic [CMD_W-1:0]    q_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int CH = $clog2(MAX_HEIGHT + 1);
   localparam int PW = 8 + MAX_BLOCK_LOG2;

   typedef struct packed {
      pafb_kind_type         kind;
      logic [AW-1:0]         addr;
      logic [BLW-1:0]        nx;
      logic [BLW-1:0]        ny;
      logic [2:0]            mark;
      logic [SAMPLE_W-1:0]   red;
      logic [SAMPLE_W-1:0]   green;
      logic [SAMPLE_W-1:0]   blue;
      logic [SAMPLE_W-1:0]   weight;
   } cmd_type;

   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic [CW-1:0]    eff_w;
   logic [CH-1:0]    eff_h;
   logic [2:0]       kk;
   logic [PW-1:0]    x0, y0;
   logic [BLW-1:0]   blk_edge, nx, ny;
   int               rem_x, rem_y;
   logic             in_image;
   logic             keep;
   cmd_type          cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(256);
         height_ff <= CSR_W'(256);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Registers above the compiled-in maximum saturate to it.
   assign eff_w = (int'(width_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_ff);
   assign eff_h = (int'(height_ff) > MAX_HEIGHT) ? CH'(MAX_HEIGHT) : CH'(height_ff);

   always_comb begin
      kk       = (int'(req_block_log2) > MAX_BLOCK_LOG2) ? 3'(MAX_BLOCK_LOG2)
                                                          : req_block_log2;
      x0       = PW'(req_pos_x) << kk;
      y0       = PW'(req_pos_y) << kk;
      blk_edge = BLW'(1) << kk;
      rem_x    = int'(eff_w) - int'(x0);
      rem_y    = int'(eff_h) - int'(y0);
      nx       = (rem_x <= 0) ? '0 : ((rem_x < int'(blk_edge)) ? BLW'(rem_x) : blk_edge);
      ny       = (rem_y <= 0) ? '0 : ((rem_y < int'(blk_edge)) ? BLW'(rem_y) : blk_edge);
      in_image = (int'(req_pos_x) < int'(eff_w)) && (int'(req_pos_y) < int'(eff_h));

      cmd.nx     = nx;
      cmd.ny     = ny;
      cmd.mark   = kk + 3'd1;
      cmd.red    = req_sample_red;
      cmd.green  = req_sample_green;
      cmd.blue   = req_sample_blue;
      cmd.weight = req_sample_weight;
      if (!req_type) begin
         cmd.kind = CMD_SPLAT;
         cmd.addr = AW'(int'(y0) * MAX_WIDTH + int'(x0));
         keep     = (nx != '0) && (ny != '0);
      end else begin
         cmd.kind = in_image ? CMD_READ : CMD_BLACK;
         // Rows are stored bottom first, so the read flips the row.
         cmd.addr = AW'((int'(eff_h) - 1 - int'(req_pos_y)) * MAX_WIDTH + int'(req_pos_x));
         keep     = 1'b1;
      end
   end

   // Splats that land wholly outside the image are taken and dropped here.
   assign full   = q_full || status.clearing;
   assign q_push = push && !full && keep;
   assign q_data = cmd;

endmodule

### design/pafb_back.sv
// Back stage: pixel read-modify-write, resolve division and gamma lookup.
// Depends on pafb_pkg, pafb_ram and the assertion macro header.
`include "progressive_accum_framebuffer_assert.svh"
module pafb_back import pafb_pkg::*; #(
   parameter int MAX_WIDTH        = PAFB_MAX_WIDTH,
   parameter int MAX_HEIGHT       = PAFB_MAX_HEIGHT,
   parameter int MAX_BLOCK_LOG2   = PAFB_MAX_BLOCK_LOG2,
   parameter int GAMMA_INDEX_BITS = PAFB_GAMMA_INDEX_BITS,
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = $clog2(DEPTH),
   localparam int BLW   = MAX_BLOCK_LOG2 + 1,
   localparam int CMD_W = 2 + AW + 2 * BLW + 3 + 4 * SAMPLE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic [CMD_W-1:0] cmd_data,
   input  logic             res_full,
   output logic             res_push,
   output logic [23:0]      res_data,
   output pafb_status_type  status
);

   localparam int G  = GAMMA_INDEX_BITS;
   localparam int SW = $clog2(G);

   typedef struct packed {
      pafb_kind_type         kind;
      logic [AW-1:0]         addr;
      logic [BLW-1:0]        nx;
      logic [BLW-1:0]        ny;
      logic [2:0]            mark;
      logic [SAMPLE_W-1:0]   red;
      logic [SAMPLE_W-1:0]   green;
      logic [SAMPLE_W-1:0]   blue;
      logic [SAMPLE_W-1:0]   weight;
   } cmd_type;

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b00_0000_0001,
      S_IDLE     = 10'b00_0000_0010,
      S_SPLAT_RD = 10'b00_0000_0100,
      S_SPLAT_WR = 10'b00_0000_1000,
      S_READ_RD  = 10'b00_0001_0000,
      S_READ_LAT = 10'b00_0010_0000,
      S_SETUP    = 10'b00_0100_0000,
      S_DIV      = 10'b00_1000_0000,
      S_GAMMA    = 10'b01_0000_0000,
      S_PUSH     = 10'b10_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       row_ff, row_in;
   logic [BLW-1:0]      cx_ff, cx_in;
   logic [BLW-1:0]      ry_ff, ry_in;
   logic [BLW-1:0]      nx_ff, nx_in;
   logic [BLW-1:0]      ny_ff, ny_in;
   logic [2:0]          mark_ff, mark_in;
   logic [SAMPLE_W-1:0] smp_ff [4];
   logic [SAMPLE_W-1:0] smp_in [4];
   logic [31:0]         val_ff [3];
   logic [31:0]         val_in [3];
   logic [31:0]         wgt_ff, wgt_in;
   logic [1:0]          chan_ff, chan_in;
   logic [31:0]         rem_ff, rem_in;
   logic [G:0]          idx_ff, idx_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [7:0]          b_ff, b_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          out_ff [3];
   logic [7:0]          out_in [3];

   cmd_type             cmd;
   logic                acc_we, mark_we;
   logic [AW-1:0]       wr_addr;
   logic [127:0]        acc_wdata, acc_rdata;
   logic [2:0]          mark_wdata, mark_rdata;
   logic [32:0]         rem2;
   logic                ge;
   logic [31:0]         vsel;
   logic [7:0]          try_b, new_b;
   logic [G:0]          thr [256];

   for (genvar k = 0; k < 256; k++) begin : g_thr
      assign thr[k] = (G + 1)'(pafb_gamma_thr(k, G));
   end

   assign cmd = cmd_type'(cmd_data);

   pafb_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_acc_ram (
      .clock   (clock),
      .we      (acc_we),
      .wr_addr (wr_addr),
      .wdata   (acc_wdata),
      .rd_addr (addr_ff),
      .rdata   (acc_rdata)
   );

   pafb_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_mark_ram (
      .clock   (clock),
      .we      (mark_we),
      .wr_addr (wr_addr),
      .wdata   (mark_wdata),
      .rd_addr (addr_ff),
      .rdata   (mark_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      addr_in  = addr_ff;
      row_in   = row_ff;
      cx_in    = cx_ff;
      ry_in    = ry_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      mark_in  = mark_ff;
      smp_in   = smp_ff;
      val_in   = val_ff;
      wgt_in   = wgt_ff;
      chan_in  = chan_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      b_in     = b_ff;
      bit_in   = bit_ff;
      out_in   = out_ff;

      cmd_pop    = 1'b0;
      res_push   = 1'b0;
      acc_we     = 1'b0;
      mark_we    = 1'b0;
      wr_addr    = addr_ff;
      mark_wdata = mark_ff;
      acc_wdata  = '0;

      rem2  = {rem_ff, 1'b0};
      ge    = (rem2 >= {1'b0, wgt_ff});
      vsel  = val_ff[chan_ff];
      try_b = b_ff | (8'd1 << bit_ff);
      new_b = (thr[try_b] <= idx_ff) ? try_b : b_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_addr    = clr_ff;
            mark_we    = 1'b1;
            mark_wdata = 3'd0;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               addr_in = cmd.addr;
               row_in  = cmd.addr;
               cx_in   = '0;
               ry_in   = '0;
               nx_in   = cmd.nx;
               ny_in   = cmd.ny;
               mark_in = cmd.mark;
               smp_in[0] = cmd.red;
               smp_in[1] = cmd.green;
               smp_in[2] = cmd.blue;
               smp_in[3] = cmd.weight;
               case (cmd.kind)
                  CMD_SPLAT: state_in = S_SPLAT_RD;
                  CMD_READ:  state_in = S_READ_RD;
                  CMD_BLACK: begin
                     out_in[0] = 8'd0;
                     out_in[1] = 8'd0;
                     out_in[2] = 8'd0;
                     state_in  = S_PUSH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SPLAT_RD: begin
            state_in = S_SPLAT_WR;
         end
         S_SPLAT_WR: begin
            acc_we  = 1'b1;
            mark_we = 1'b1;
            // A full-resolution pixel accumulates; an empty or coarser one is replaced.
            if (mark_rdata == 3'd1) begin
               mark_wdata = 3'd1;
               acc_wdata  = {pafb_sat_add(acc_rdata[127:96], smp_ff[0]),
                             pafb_sat_add(acc_rdata[95:64], smp_ff[1]),
                             pafb_sat_add(acc_rdata[63:32], smp_ff[2]),
                             pafb_sat_add(acc_rdata[31:0], smp_ff[3])};
            end else begin
               mark_wdata = mark_ff;
               acc_wdata  = {32'(smp_ff[0]), 32'(smp_ff[1]),
                             32'(smp_ff[2]), 32'(smp_ff[3])};
            end
            state_in = S_SPLAT_RD;
            if (cx_ff == nx_ff - BLW'(1)) begin
               if (ry_ff == ny_ff - BLW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  row_in  = row_ff + AW'(MAX_WIDTH);
                  addr_in = row_ff + AW'(MAX_WIDTH);
                  cx_in   = '0;
                  ry_in   = ry_ff + BLW'(1);
               end
            end else begin
               addr_in = addr_ff + AW'(1);
               cx_in   = cx_ff + BLW'(1);
            end
         end
         S_READ_RD: begin
            state_in = S_READ_LAT;
         end
         S_READ_LAT: begin
            val_in[0] = acc_rdata[127:96];
            val_in[1] = acc_rdata[95:64];
            val_in[2] = acc_rdata[63:32];
            wgt_in    = acc_rdata[31:0];
            chan_in   = 2'd0;
            state_in  = S_SETUP;
         end
         S_SETUP: begin
            b_in    = 8'd0;
            bit_in  = 3'd7;
            rem_in  = vsel;
            idx_in  = '0;
            step_in = '0;
            // Zero weight reads black; a ratio of one or more clamps to full scale.
            if (wgt_ff == 32'd0) begin
               state_in = S_GAMMA;
            end else if (vsel >= wgt_ff) begin
               idx_in   = (G + 1)'(1) << G;
               state_in = S_GAMMA;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? 32'(rem2 - {1'b0, wgt_ff}) : rem2[31:0];
            idx_in  = {idx_ff[G-1:0], ge};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(G - 1)) state_in = S_GAMMA;
         end
         S_GAMMA: begin
            b_in   = new_b;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               out_in[chan_ff] = new_b;
               if (chan_ff == 2'd2) begin
                  state_in = S_PUSH;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = S_SETUP;
               end
            end
         end
         S_PUSH: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      addr_ff <= addr_in;
      row_ff  <= row_in;
      cx_ff   <= cx_in;
      ry_ff   <= ry_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      mark_ff <= mark_in;
      smp_ff  <= smp_in;
      val_ff  <= val_in;
      wgt_ff  <= wgt_in;
      chan_ff <= chan_in;
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      b_ff    <= b_in;
      bit_ff  <= bit_in;
      out_ff  <= out_in;
   end

   assign res_data        = {out_ff[0], out_ff[1], out_ff[2]};
   assign status.clearing = (state_ff == S_CLEAR);

   `PAFB_ASSERT(a_no_result_in_clear, clock, reset, (state_ff == S_CLEAR) |-> !res_push, "result pushed during clearing pass")
   `PAFB_ASSERT(a_pop_only_idle, clock, reset, cmd_pop |-> (state_ff == S_IDLE), "request popped outside idle")
   `PAFB_ASSERT(a_mark_write_states, clock, reset, mark_we |-> (state_ff == S_SPLAT_WR || state_ff == S_CLEAR), "mark memory written outside splat or clear")
   `PAFB_ASSERT(a_gamma_monotone, clock, reset, (state_ff == S_GAMMA && $past(state_ff) == S_GAMMA) |-> (b_ff >= $past(b_ff)), "gamma search moved backward")
   `PAFB_ASSERT(a_div_bounded, clock, reset, (state_ff == S_DIV) |-> (rem_ff < wgt_ff), "division remainder not below weight")

endmodule

### design/progressive_accum_framebuffer.sv
// Top level of the progressive accumulation framebuffer.
// Depends on pafb_pkg, pafb_front, pafb_queue and pafb_back.
//
//   channel   handshake           payload
//   request   push / full         req_type, req_pos_x/y, req_block_log2, req_sample_*
//   response  pop / empty         rsp_out_red, rsp_out_green, rsp_out_blue
//   csr       csr_valid/csr_ready csr_index, csr_data
//
// A splat is dispatched from idle, then takes a memory read and a write back
// for each covered in-image pixel.
// A read resolves each channel in turn through the shared bit-serial divider
// and the 8-step gamma search.
// After reset a clearing pass over all MAX_WIDTH * MAX_HEIGHT entries zeroes the size
// marks; full stays high during it, csr writes are taken throughout.
// Two-entry queues on each side let the request and response sides stall apart.
module progressive_accum_framebuffer import pafb_pkg::*; #(
   parameter int MAX_WIDTH        = PAFB_MAX_WIDTH,
   parameter int MAX_HEIGHT       = PAFB_MAX_HEIGHT,
   parameter int MAX_BLOCK_LOG2   = PAFB_MAX_BLOCK_LOG2,
   parameter int GAMMA_INDEX_BITS = PAFB_GAMMA_INDEX_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   input  logic                push,
   output logic                full,
   input  logic                req_type,
   input  logic [7:0]          req_pos_x,
   input  logic [7:0]          req_pos_y,
   input  logic [2:0]          req_block_log2,
   input  logic [SAMPLE_W-1:0] req_sample_red,
   input  logic [SAMPLE_W-1:0] req_sample_green,
   input  logic [SAMPLE_W-1:0] req_sample_blue,
   input  logic [SAMPLE_W-1:0] req_sample_weight,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int BLW   = MAX_BLOCK_LOG2 + 1;
   localparam int CMD_W = 2 + AW + 2 * BLW + 3 + 4 * SAMPLE_W;

   pafb_status_type  status;
   logic             cq_push, cq_full, cq_pop, cq_empty;
   logic [CMD_W-1:0] cq_wdata, cq_rdata;
   logic             rq_push, rq_full;
   logic [23:0]      rq_wdata, rq_rdata;

   pafb_front #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_block_log2    (req_block_log2),
      .req_sample_red    (req_sample_red),
      .req_sample_green  (req_sample_green),
      .req_sample_blue   (req_sample_blue),
      .req_sample_weight (req_sample_weight),
      .status            (status),
      .q_full            (cq_full),
      .q_push            (cq_push),
      .q_data            (cq_wdata)
   );

   pafb_queue #(.WIDTH(CMD_W)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cq_push),
      .wdata (cq_wdata),
      .full  (cq_full),
      .pop   (cq_pop),
      .rdata (cq_rdata),
      .empty (cq_empty)
   );

   pafb_back #(
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_HEIGHT       (MAX_HEIGHT),
      .MAX_BLOCK_LOG2   (MAX_BLOCK_LOG2),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cq_empty),
      .cmd_pop   (cq_pop),
      .cmd_data  (cq_rdata),
      .res_full  (rq_full),
      .res_push  (rq_push),
      .res_data  (rq_wdata),
      .status    (status)
   );

   pafb_queue #(.WIDTH(24)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata (rq_wdata),
      .full  (rq_full),
      .pop   (pop),
      .rdata (rq_rdata),
      .empty (empty)
   );

   assign rsp_out_red   = rq_rdata[23:16];
   assign rsp_out_green = rq_rdata[15:8];
   assign rsp_out_blue  = rq_rdata[7:0];

endmodule

### tb/sv/progressive_accum_framebuffer_tb.sv
// Self-checking testbench for the progressive accumulation framebuffer.
// Depends on pafb_pkg and the progressive_accum_framebuffer RTL only.
// Predicts every read response from its own copy of the pixel sums and size marks.
`timescale 1ns / 100ps

module progressive_accum_framebuffer_tb;
   import pafb_pkg::*;

   localparam int NUM_PIX = PAFB_MAX_WIDTH * PAFB_MAX_HEIGHT;
   localparam int GBITS = PAFB_GAMMA_INDEX_BITS;
   localparam int SPLAT_DRAIN = 1600;
   localparam int STALL_LIMIT = 200000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   logic clock, reset;
   logic csr_valid, csr_ready, csr_index;
   logic [CSR_W-1:0] csr_data;
   logic push, full, req_type;
   logic [7:0] req_pos_x, req_pos_y;
   logic [2:0] req_block_log2;
   logic [SAMPLE_W-1:0] req_sample_red, req_sample_green, req_sample_blue, req_sample_weight;
   logic empty, pop;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;

   // Predicted framebuffer contents.
   logic [31:0] sum_red[NUM_PIX];
   logic [31:0] sum_green[NUM_PIX];
   logic [31:0] sum_blue[NUM_PIX];
   logic [31:0] sum_weight[NUM_PIX];
   logic [2:0] size_mark[NUM_PIX];
   int written_pix_q[$];
   int gamma_thr[256];
   int width_eff, height_eff;

   pixel_rgb_type pixel_expect_q[$];
   int errors, tx_idle_pct, rx_idle_pct, hold_left, stall_cycles;
   int splats_sent, reads_sent, pixels_checked;

   progressive_accum_framebuffer dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Largest gamma byte b with (b/255)^2.2 <= idx/N, found as thresholds on idx.
   task automatic build_gamma_thresholds();
      logic [191:0] target, trial, scale;
      int lo, hi, mid;
      scale = 192'd1;
      for (int i = 0; i < 11; i++) scale = scale * 192'd255;
      gamma_thr[0] = 0;
      for (int b = 1; b < 256; b++) begin
         target = 192'd1;
         for (int i = 0; i < 11; i++) target = target * 192'(b);
         target = target << (5 * GBITS);
         lo = 0;
         hi = 1 << GBITS;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            trial = scale;
            for (int i = 0; i < 5; i++) trial = trial * 192'(mid);
            if (trial >= target) hi = mid;
            else lo = mid + 1;
         end
         gamma_thr[b] = lo;
      end
   endtask

   function automatic logic [7:0] gamma_byte(logic [31:0] v, logic [31:0] w);
      logic [63:0] idx;
      logic [7:0] b;
      if (w == 0) return 8'd0;
      idx = 64'({v, 12'd0} / w);
      if (idx > (64'd1 << GBITS)) idx = 64'd1 << GBITS;
      b = 0;
      for (int k = 1; k < 256; k++) if (gamma_thr[k] <= idx) b = 8'(k);
      return b;
   endfunction

   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [SAMPLE_W-1:0] s);
      logic [32:0] t;
      t = {1'b0, a} + {9'd0, s};
      return t[32] ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   task automatic apply_splat(int px, int py, int k, logic [SAMPLE_W-1:0] r,
                              logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] bl,
                              logic [SAMPLE_W-1:0] wt);
      int x, y, i;
      if (k > PAFB_MAX_BLOCK_LOG2) k = PAFB_MAX_BLOCK_LOG2;
      for (int dy = 0; dy < (1 << k); dy++) begin
         y = (py << k) + dy;
         if (y >= height_eff) break;
         for (int dx = 0; dx < (1 << k); dx++) begin
            x = (px << k) + dx;
            if (x >= width_eff) break;
            i = y * PAFB_MAX_WIDTH + x;
            if (size_mark[i] == 0) written_pix_q.insert(written_pix_q.size(), i);
            if (size_mark[i] != 3'd1) begin
               sum_red[i] = r;
               sum_green[i] = g;
               sum_blue[i] = bl;
               sum_weight[i] = wt;
               size_mark[i] = 3'(k + 1);
            end else begin
               sum_red[i] = add_clamped(sum_red[i], r);
               sum_green[i] = add_clamped(sum_green[i], g);
               sum_blue[i] = add_clamped(sum_blue[i], bl);
               sum_weight[i] = add_clamped(sum_weight[i], wt);
            end
         end
      end
   endtask

   function automatic pixel_rgb_type resolve_pixel(int px, int py);
      pixel_rgb_type p;
      int i;
      p = '{8'd0, 8'd0, 8'd0};
      if (px < width_eff && py < height_eff) begin
         i = (height_eff - 1 - py) * PAFB_MAX_WIDTH + px;
         p.red = gamma_byte(sum_red[i], sum_weight[i]);
         p.green = gamma_byte(sum_green[i], sum_weight[i]);
         p.blue = gamma_byte(sum_blue[i], sum_weight[i]);
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Sends one request, waits for it to be taken, then updates the prediction.
   task automatic send_item(logic typ, int px, int py, int k, logic [SAMPLE_W-1:0] r,
                            logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] bl,
                            logic [SAMPLE_W-1:0] wt);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_type <= typ;
      req_pos_x <= 8'(px);
      req_pos_y <= 8'(py);
      req_block_log2 <= 3'(k);
      req_sample_red <= r;
      req_sample_green <= g;
      req_sample_blue <= bl;
      req_sample_weight <= wt;
      do @(posedge clock); while (full);
      if (typ == 1'(CMD_READ)) begin
         pixel_expect_q.insert(pixel_expect_q.size(), resolve_pixel(px, py));
         reads_sent++;
      end else begin
         apply_splat(px, py, k, r, g, bl, wt);
         splats_sent++;
      end
   endtask

   task automatic read_pixel(int x, int y);
      send_item(1'(CMD_READ), x, height_eff - 1 - y, 0, '0, '0, '0, '0);
   endtask

   task automatic splat(int px, int py, int k, logic [SAMPLE_W-1:0] r,
                        logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] bl,
                        logic [SAMPLE_W-1:0] wt);
      send_item(1'(CMD_SPLAT), px, py, k, r, g, bl, wt);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      // Splats have no response, so give the queued ones time to finish.
      repeat (SPLAT_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         width_eff = (int'(value) > PAFB_MAX_WIDTH) ? PAFB_MAX_WIDTH : int'(value);
      else
         height_eff = (int'(value) > PAFB_MAX_HEIGHT) ? PAFB_MAX_HEIGHT : int'(value);
   endtask

   task automatic set_image(int w, int h);
      write_csr(CSR_IMAGE_WIDTH, CSR_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_W'(h));
   endtask

   task automatic random_item();
      int k, px, py, i, x, y;
      bit found;
      if ($urandom_range(0, 1) == 0 || written_pix_q.size() == 0) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
         if ($urandom_range(0, 7) == 0) begin
            px = $urandom_range(0, 255);
            py = $urandom_range(0, 255);
         end else begin
            px = $urandom_range(0, (width_eff - 1) >> (k > 4 ? 4 : k));
            py = $urandom_range(0, (height_eff - 1) >> (k > 4 ? 4 : k));
         end
         splat(px, py, k, SAMPLE_W'($urandom_range(0, 24'hFFFFFF)),
               SAMPLE_W'($urandom_range(0, 24'hFFFFFF)),
               SAMPLE_W'($urandom_range(0, 24'hFFFFFF)),
               ($urandom_range(0, 15) == 0) ? '0 : SAMPLE_W'($urandom_range(0, 24'hFFFFFF)));
         return;
      end
      found = 0;
      for (int t = 0; t < 8 && !found; t++) begin
         i = written_pix_q[$urandom_range(0, written_pix_q.size() - 1)];
         x = i % PAFB_MAX_WIDTH;
         y = i / PAFB_MAX_WIDTH;
         found = (x < width_eff && y < height_eff);
      end
      if (found && $urandom_range(0, 9) != 0) read_pixel(x, y);
      else if (width_eff < 256)
         send_item(1'(CMD_READ), $urandom_range(width_eff, 255), $urandom_range(0, 255), 0,
                   '0, '0, '0, '0);
      else if (height_eff < 256)
         send_item(1'(CMD_READ), $urandom_range(0, 255), $urandom_range(height_eff, 255), 0,
                   '0, '0, '0, '0);
      else if (found) read_pixel(x, y);
   endtask

   task automatic test_extremes();
      splat(0, 0, 0, 24'hFFFFFF, 24'h000000, 24'h800000, 24'h010000);
      read_pixel(0, 0);
      splat(255, 255, 0, 24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFFFFFF);
      read_pixel(255, 255);
      splat(1, 0, 0, 24'h123456, 24'h654321, 24'hABCDEF, 24'h000000);
      read_pixel(1, 0);
      // A coarse block is overwritten by a finer one.
      splat(1, 1, 3, 24'h020000, 24'h030000, 24'h040000, 24'h050000);
      read_pixel(9, 10);
      splat(9, 10, 0, 24'h001000, 24'h002000, 24'h003000, 24'h004000);
      splat(9, 10, 2, 24'h001000, 24'h000000, 24'h003000, 24'h004000);
      read_pixel(9, 10);
      // Block sizes above the maximum behave as the largest block.
      splat(2, 2, 7, 24'h0F0000, 24'h0A0000, 24'h050000, 24'h100000);
      read_pixel(47, 47);
      splat(3, 2, 5, 24'h000001, 24'h000002, 24'h000003, 24'h7FFFFF);
      read_pixel(48, 32);
      send_item(1'(CMD_READ), 255, 0, 0, '0, '0, '0, '0);
      drain();
   endtask

   task automatic test_saturation();
      splat(5, 200, 0, 24'h000100, 24'h000100, 24'h000100, 24'h000100);
      for (int n = 0; n < 260; n++)
         splat(5, 200, 0, 24'hFFFFFF, 24'h7FFFFF, 24'h00FFFF, 24'h3FFFFF);
      read_pixel(5, 200);
      drain();
   endtask

   task automatic test_registers();
      set_image(20, 20);
      splat(1, 1, 4, 24'h111111, 24'h222222, 24'h333333, 24'h444444);
      read_pixel(19, 19);
      send_item(1'(CMD_READ), 20, 0, 0, '0, '0, '0, '0);
      send_item(1'(CMD_READ), 0, 20, 0, '0, '0, '0, '0);
      drain();
      set_image(0, 511);
      splat(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000001);
      send_item(1'(CMD_READ), 0, 0, 0, '0, '0, '0, '0);
      drain();
      set_image(300, 1);
      splat(200, 0, 0, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h000F00);
      read_pixel(200, 0);
      send_item(1'(CMD_READ), 3, 1, 0, '0, '0, '0, '0);
      drain();
      set_image(256, 256);
   endtask

   task automatic test_backpressure();
      drain();
      hold_left = 400;
      for (int n = 0; n < 30; n++) random_item();
      drain();
   endtask

   task automatic test_random(int w, int h, int tx_pct, int rx_pct, int count);
      set_image(w, h);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int n = 0; n < count; n++) begin
         random_item();
         // Once, halfway through, let everything settle before going on.
         if (n == count / 2) drain();
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else begin
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      pixel_rgb_type want;
      if (!reset && pop && !empty) begin
         if (pixel_expect_q.size() == 0) begin
            $display("%0t response with no read waiting", $realtime);
            errors++;
         end else begin
            want = pixel_expect_q[0];
            pixel_expect_q.delete(0);
            pixels_checked++;
            if (rsp_out_red !== want.red)
               report_mismatch("red", int'(rsp_out_red), int'(want.red));
            if (rsp_out_green !== want.green)
               report_mismatch("green", int'(rsp_out_green), int'(want.green));
            if (rsp_out_blue !== want.blue)
               report_mismatch("blue", int'(rsp_out_blue), int'(want.blue));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      errors = 0;
      splats_sent = 0;
      reads_sent = 0;
      pixels_checked = 0;
      hold_left = 0;
      stall_cycles = 0;
      tx_idle_pct = 21;
      rx_idle_pct = 45;
      width_eff = PAFB_MAX_WIDTH;
      height_eff = PAFB_MAX_HEIGHT;
      foreach (size_mark[i]) size_mark[i] = 3'd0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data <= '0;
      push <= 1'b0;
      pop <= 1'b0;
      req_type <= 1'(CMD_SPLAT);
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_block_log2 <= '0;
      req_sample_red <= '0;
      req_sample_green <= '0;
      req_sample_blue <= '0;
      req_sample_weight <= '0;
      build_gamma_thresholds();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_registers();
      test_saturation();
      test_backpressure();
      test_random(256, 256, 21, 45, 200);
      test_random(45, 130, 45, 21, 200);
      test_random(16, 16, 0, 0, 200);

      $display("Covered %0d splats and %0d reads, %0d responses checked,", splats_sent,
               reads_sent, pixels_checked);
      $display("across image sizes from empty to full, with stalls on both sides.");
      if (errors == 0 && pixel_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
